// ===== hdl/sadf_pkg.sv =====
// Shared types and constants for the server address list deframer.
// No dependencies; every other file imports this package.
package sadf_pkg;

  // parse phase codes
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_PORT_LO = 3'd3;
  localparam logic [2:0] PH_PORT_HI = 3'd4;
  localparam logic [2:0] PH_IGNORE  = 3'd5;

  localparam int unsigned CountW = 7;

  localparam logic [7:0] PREFIX_V4 = 8'h5C;  // backslash
  localparam logic [7:0] PREFIX_V6 = 8'h2F;  // slash
  localparam logic [CountW-1:0] V4_BYTES = CountW'(4);
  localparam logic [CountW-1:0] V6_BYTES = CountW'(16);

  typedef enum logic [2:0] {
    KIND_ADDRESS   = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_ZERO_PORT = 3'd2,
    KIND_BAD_PREFIX = 3'd3,
    KIND_TRUNCATED = 3'd4,
    KIND_HDR_SHORT = 3'd5
  } kind_e;

  // queue depth between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // one queue entry: an optional record followed by an optional status
  typedef struct packed {
    logic        rec;
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic        stat;
    kind_e       stat_kind;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

// ===== hdl/sadf_ifs.sv =====
// Handshake channel interfaces: message bytes in, results out, config write.
// Depends on sadf_pkg.
interface sadf_in_if import sadf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sadf_out_if import sadf_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic        is_ipv6;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [15:0] port_number;
  logic        final_result;
  modport source (output valid, output result_kind, output is_ipv6, output address_high,
                  output address_low, output port_number, output final_result,
                  input ready);
  modport sink   (input valid, input result_kind, input is_ipv6, input address_high,
                  input address_low, input port_number, input final_result,
                  output ready);
endinterface

interface sadf_cfg_if import sadf_pkg::*;;
  logic valid;
  logic ready;
  logic listening;
  modport source (output valid, output listening, input ready);
  modport sink   (input valid, input listening, output ready);
endinterface

// ===== hdl/server_address_list_deframer_unit.sv =====
// Top level of the server address list deframer: front parser, entry queue,
// result back end. Depends on sadf_pkg, sadf_ifs, sadf_front, sadf_queue, sadf_back.
//
//  channel        dir  handshake     payload
//  in_byte_i      in   valid/ready   data_byte[7:0], last_byte
//  cfg_i          in   valid/ready   listening (ready always high)
//  out_result_o   out  valid/ready   result_kind, is_ipv6, address_high/low,
//                                    port_number, final_result
//
// One byte per clock is accepted while the 4-entry queue has room; the front
// parser is a phase machine that decodes each accepted byte combinationally.
// Results leave one per clock from the output register while ready is high.
// Input ready drops only when the queue fills under output back-pressure.
// Reset (rst_ni low, async) clears listening, the parse phase and the queue.
module server_address_list_deframer_unit import sadf_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sadf_in_if.sink    in_byte_i,
  sadf_cfg_if.sink   cfg_i,
  sadf_out_if.source out_result_o
);

  push_t  push;
  entry_t head;
  logic   q_empty, q_full, pop;

  sadf_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_byte_i),
    .cfg_i     (cfg_i),
    .q_full_i  (q_full),
    .push_o    (push)
  );

  sadf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sadf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_result_o (out_result_o)
  );

endmodule

// ===== hdl/sadf_front.sv =====
// Front end: accepts message bytes, tracks the parse phase, assembles records
// and pushes record/status entries to the queue. Depends on sadf_pkg, sadf_ifs.
module sadf_front import sadf_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sadf_in_if.sink    in_byte_i,
  sadf_cfg_if.sink   cfg_i,
  input  logic       q_full_i,
  output push_t      push_o
);

  localparam logic [CountW:0] HdrLen = (CountW+1)'(HEADER_BYTES);
  localparam logic [2:0] StartPhase = (HEADER_BYTES > 0) ? PH_HEADER : PH_PREFIX;

  logic              listening_q;
  logic [2:0]        phase_q, phase_d, phase_mid;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW:0]   count_inc;
  logic              v6_q, v6_d;
  logic [63:0]       shift_hi_q, shift_hi_d, shift_lo_q, shift_lo_d;
  logic [7:0]        port_lo_q, port_lo_d;
  logic [15:0]       port_word;
  logic              accept;
  logic [7:0]        b;

  assign in_byte_i.ready = !q_full_i;
  assign cfg_i.ready     = 1'b1;
  assign accept          = in_byte_i.valid && in_byte_i.ready;
  assign b               = in_byte_i.data_byte;
  assign count_inc       = {1'b0, count_q} + (CountW+1)'(1);
  assign port_word       = {b, port_lo_q};

  always_comb begin
    phase_mid  = phase_q;
    phase_d    = phase_q;
    count_d    = count_q;
    v6_d       = v6_q;
    shift_hi_d = shift_hi_q;
    shift_lo_d = shift_lo_q;
    port_lo_d  = port_lo_q;
    push_o     = '0;
    push_o.entry.stat_kind = KIND_DONE;
    if (accept) begin
      if (!listening_q) begin
        if (in_byte_i.last_byte) begin
          phase_d = StartPhase;
          count_d = '0;
        end else begin
          phase_d = PH_IGNORE;
        end
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            count_d = count_inc[CountW-1:0];
            if (count_inc >= HdrLen) begin
              phase_mid = PH_PREFIX;
              count_d   = '0;
            end
          end
          PH_PREFIX: begin
            if (b == PREFIX_V4 || b == PREFIX_V6) begin
              v6_d       = (b == PREFIX_V6);
              shift_hi_d = '0;
              shift_lo_d = '0;
              count_d    = '0;
              phase_mid  = PH_ADDR;
            end else begin
              push_o.entry.stat      = 1'b1;
              push_o.entry.stat_kind = KIND_BAD_PREFIX;
              phase_mid              = PH_IGNORE;
            end
          end
          PH_ADDR: begin
            shift_hi_d = {shift_hi_q[55:0], shift_lo_q[63:56]};
            shift_lo_d = {shift_lo_q[55:0], b};
            count_d    = count_inc[CountW-1:0];
            if (count_inc >= {1'b0, (v6_q ? V6_BYTES : V4_BYTES)}) phase_mid = PH_PORT_LO;
          end
          PH_PORT_LO: begin
            port_lo_d = b;
            phase_mid = PH_PORT_HI;
          end
          PH_PORT_HI: begin
            if (port_word == 16'd0) begin
              push_o.entry.stat      = 1'b1;
              push_o.entry.stat_kind = KIND_ZERO_PORT;
              phase_mid              = PH_IGNORE;
            end else begin
              push_o.entry.rec     = 1'b1;
              push_o.entry.is_ipv6 = v6_q;
              push_o.entry.addr_hi = v6_q ? shift_hi_q : 64'd0;
              push_o.entry.addr_lo = v6_q ? shift_lo_q : {32'd0, shift_lo_q[31:0]};
              push_o.entry.port    = port_word;
              phase_mid            = PH_PREFIX;
            end
          end
          default: ;  // ignore phase and unused codes
        endcase
        phase_d = phase_mid;
        if (in_byte_i.last_byte) begin
          priority if (phase_mid == PH_PREFIX) begin
            push_o.entry.stat      = 1'b1;
            push_o.entry.stat_kind = KIND_DONE;
          end else if (phase_mid == PH_HEADER) begin
            push_o.entry.stat      = 1'b1;
            push_o.entry.stat_kind = KIND_HDR_SHORT;
          end else if (phase_mid == PH_ADDR || phase_mid == PH_PORT_LO ||
                       phase_mid == PH_PORT_HI) begin
            push_o.entry.stat      = 1'b1;
            push_o.entry.stat_kind = KIND_TRUNCATED;
          end else begin
            // a stop status was already pushed, or the message is ignored
          end
          phase_d = StartPhase;
          count_d = '0;
        end
      end
    end
    push_o.valid = push_o.entry.rec || push_o.entry.stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q <= 1'b0;
      phase_q     <= StartPhase;
      count_q     <= '0;
      v6_q        <= 1'b0;
      shift_hi_q  <= '0;
      shift_lo_q  <= '0;
      port_lo_q   <= '0;
    end else begin
      if (cfg_i.valid) listening_q <= cfg_i.listening;
      phase_q    <= phase_d;
      count_q    <= count_d;
      v6_q       <= v6_d;
      shift_hi_q <= shift_hi_d;
      shift_lo_q <= shift_lo_d;
      port_lo_q  <= port_lo_d;
    end
  end

endmodule

// ===== hdl/sadf_queue.sv =====
// Short FIFO of record/status entries between front and back.
// Depends on sadf_pkg.
module sadf_queue import sadf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_ptr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      unique case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + (QPtrW+1)'(1);
        2'b01:   count_q <= count_q - (QPtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/sadf_back.sv =====
// Back end: drains queue entries into the output register, a record first
// and its trailing status next. Depends on sadf_pkg, sadf_ifs.
module sadf_back import sadf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  entry_t    head_i,
  input  logic      empty_i,
  output logic      pop_o,
  sadf_out_if.source out_result_o
);

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  kind_e       pend_kind_q, pend_kind_d;
  logic        load;
  logic [2:0]  kind_q, kind_d;
  logic        v6_q, v6_d, fin_q, fin_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;
  logic [15:0] port_q, port_d;

  assign load = !valid_q || out_result_o.ready;

  always_comb begin
    pop_o       = 1'b0;
    valid_d     = valid_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    kind_d      = kind_q;
    v6_d        = v6_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    port_d      = port_q;
    fin_d       = fin_q;
    if (load) begin
      valid_d = 1'b0;
      priority if (pend_q) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        kind_d  = pend_kind_q;
        v6_d    = 1'b0;
        hi_d    = '0;
        lo_d    = '0;
        port_d  = '0;
        fin_d   = 1'b1;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        if (head_i.rec) begin
          kind_d      = KIND_ADDRESS;
          v6_d        = head_i.is_ipv6;
          hi_d        = head_i.addr_hi;
          lo_d        = head_i.addr_lo;
          port_d      = head_i.port;
          fin_d       = 1'b0;
          pend_d      = head_i.stat;
          pend_kind_d = head_i.stat_kind;
        end else begin
          kind_d = head_i.stat_kind;
          v6_d   = 1'b0;
          hi_d   = '0;
          lo_d   = '0;
          port_d = '0;
          fin_d  = 1'b1;
        end
      end else begin
        // nothing to show
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    kind_q      <= kind_d;
    v6_q        <= v6_d;
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    port_q      <= port_d;
    fin_q       <= fin_d;
  end

  assign out_result_o.valid        = valid_q;
  assign out_result_o.result_kind  = kind_q;
  assign out_result_o.is_ipv6      = v6_q;
  assign out_result_o.address_high = hi_q;
  assign out_result_o.address_low  = lo_q;
  assign out_result_o.port_number  = port_q;
  assign out_result_o.final_result = fin_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for server_address_list_deframer_unit: directed message table,
// then random response messages with bursty requests and result stalls.
// Depends on sadf_pkg, the sadf_*_if interfaces and the deframer RTL.
module tb import sadf_pkg::*;;

  localparam int unsigned HEADER_BYTES   = 25;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    kind_e       kind;
    logic        is_ipv6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic        fin;
  } addr_result_t;

  typedef enum logic [2:0] {
    SH_HEADER,      // header bytes only, count in extra
    SH_RECORD,      // header + one record, cut to extra record bytes when nonzero
    SH_TWO,         // header + record + record of the other family
    SH_ZERO_PORT,   // header + record with port 0 + extra trailing bytes
    SH_BAD_PREFIX,  // header + addr[7:0] as prefix + extra trailing bytes
    SH_SPLIT        // record message, listening turned on after extra bytes
  } shape_e;

  typedef struct packed {
    shape_e       shape;
    logic         listen;
    logic         v6;
    logic [127:0] addr;
    logic [15:0]  port;
    logic [7:0]   extra;
    logic         typed;
    kind_e        status;
  } scenario_t;

  localparam int unsigned NUM_DIRECTED = 20;
  localparam scenario_t DIRECTED [NUM_DIRECTED] = '{
    '{SH_RECORD,     1'b0, 1'b0, 128'h0a000001, 16'h1234, 8'd0,  1'b0, KIND_DONE},
    '{SH_SPLIT,      1'b0, 1'b0, 128'hc0a80101, 16'h6d6d, 8'd10, 1'b0, KIND_DONE},
    '{SH_HEADER,     1'b1, 1'b0, 128'h0,        16'h0,    8'd1,  1'b1, KIND_HDR_SHORT},
    '{SH_HEADER,     1'b1, 1'b0, 128'h0,        16'h0,    8'd24, 1'b1, KIND_HDR_SHORT},
    '{SH_HEADER,     1'b1, 1'b0, 128'h0,        16'h0,    8'd25, 1'b1, KIND_DONE},
    '{SH_RECORD,     1'b1, 1'b0, 128'h0,        16'h0001, 8'd0,  1'b1, KIND_DONE},
    '{SH_RECORD,     1'b1, 1'b0, ~128'h0,       16'hffff, 8'd0,  1'b1, KIND_DONE},
    '{SH_RECORD,     1'b1, 1'b1, 128'h0,        16'h0100, 8'd0,  1'b1, KIND_DONE},
    '{SH_RECORD,     1'b1, 1'b1, ~128'h0,       16'hffff, 8'd0,  1'b1, KIND_DONE},
    '{SH_TWO,        1'b1, 1'b0, 128'h2001_0db8_8000_0042_1234_5678_9abc_def0,
      16'h6d78, 8'd0, 1'b1, KIND_DONE},
    '{SH_TWO,        1'b1, 1'b1, 128'h8000_0000_0000_0001_7fff_ffff_ffff_fffe,
      16'h8001, 8'd0, 1'b1, KIND_DONE},
    '{SH_ZERO_PORT,  1'b1, 1'b0, 128'h5c2f5c2f, 16'h0,    8'd5,  1'b1, KIND_ZERO_PORT},
    '{SH_ZERO_PORT,  1'b1, 1'b1, 128'h1,        16'h0,    8'd0,  1'b1, KIND_ZERO_PORT},
    '{SH_BAD_PREFIX, 1'b1, 1'b0, 128'h00,       16'h0,    8'd3,  1'b1, KIND_BAD_PREFIX},
    '{SH_BAD_PREFIX, 1'b1, 1'b0, 128'hff,       16'h0,    8'd0,  1'b1, KIND_BAD_PREFIX},
    '{SH_RECORD,     1'b1, 1'b0, 128'h01020304, 16'h0050, 8'd1,  1'b1, KIND_TRUNCATED},
    '{SH_RECORD,     1'b1, 1'b1, 128'h5555,     16'h0050, 8'd9,  1'b1, KIND_TRUNCATED},
    '{SH_RECORD,     1'b1, 1'b0, 128'haabbccdd, 16'h0050, 8'd6,  1'b1, KIND_TRUNCATED},
    '{SH_RECORD,     1'b1, 1'b1, 128'h7777,     16'h0050, 8'd17, 1'b1, KIND_TRUNCATED},
    '{SH_RECORD,     1'b0, 1'b1, 128'h9999,     16'h0050, 8'd0,  1'b0, KIND_DONE}
  };

  logic clk_i;
  logic rst_ni;

  sadf_in_if  in_if ();
  sadf_cfg_if cfg_if ();
  sadf_out_if out_if ();

  server_address_list_deframer_unit #(
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_if),
    .cfg_i       (cfg_if),
    .out_result_o(out_if)
  );

  // parser mirror
  logic        listen_cfg;
  logic [2:0]  phase;
  logic [6:0]  byte_cnt;
  logic        rec_v6;
  logic [63:0] shift_hi;
  logic [63:0] shift_lo;
  logic [7:0]  port_lo;

  addr_result_t pending_results[$];

  int unsigned mismatch_cnt;
  int unsigned bytes_sent;
  int unsigned bytes_listening;
  int unsigned records_seen;
  int unsigned status_seen;
  int unsigned cfg_writes;
  int unsigned burst_left;
  int unsigned gap_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void queue_result(kind_e k, logic v6, logic [63:0] hi, logic [63:0] lo,
                                       logic [15:0] port, logic fin);
    addr_result_t r;
    r.kind    = k;
    r.is_ipv6 = v6;
    r.hi      = hi;
    r.lo      = lo;
    r.port    = port;
    r.fin     = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void restart_message();
    phase    = (HEADER_BYTES > 0) ? PH_HEADER : PH_PREFIX;
    byte_cnt = '0;
  endfunction

  // advance the parser mirror by one accepted byte, queueing what it emits
  function automatic void parse_byte(logic [7:0] b, logic last);
    logic [15:0] port;
    if (!listen_cfg) begin
      if (last) restart_message();
      else phase = PH_IGNORE;
      return;
    end
    case (phase)
      PH_HEADER: begin
        byte_cnt = byte_cnt + 7'd1;
        if (byte_cnt >= HEADER_BYTES) begin
          phase    = PH_PREFIX;
          byte_cnt = '0;
        end
      end
      PH_PREFIX: begin
        if (b == PREFIX_V4 || b == PREFIX_V6) begin
          rec_v6   = (b == PREFIX_V6);
          shift_hi = '0;
          shift_lo = '0;
          byte_cnt = '0;
          phase    = PH_ADDR;
        end else begin
          queue_result(KIND_BAD_PREFIX, 1'b0, '0, '0, '0, 1'b1);
          phase = PH_IGNORE;
        end
      end
      PH_ADDR: begin
        {shift_hi, shift_lo} = {shift_hi[55:0], shift_lo, b};
        byte_cnt = byte_cnt + 7'd1;
        if (byte_cnt >= (rec_v6 ? V6_BYTES : V4_BYTES)) phase = PH_PORT_LO;
      end
      PH_PORT_LO: begin
        port_lo = b;
        phase   = PH_PORT_HI;
      end
      PH_PORT_HI: begin
        port = {b, port_lo};
        if (port == 16'h0) begin
          queue_result(KIND_ZERO_PORT, 1'b0, '0, '0, '0, 1'b1);
          phase = PH_IGNORE;
        end else begin
          queue_result(KIND_ADDRESS, rec_v6, rec_v6 ? shift_hi : 64'h0,
                       rec_v6 ? shift_lo : {32'h0, shift_lo[31:0]}, port, 1'b0);
          phase = PH_PREFIX;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (phase == PH_PREFIX)
        queue_result(KIND_DONE, 1'b0, '0, '0, '0, 1'b1);
      else if (phase == PH_HEADER)
        queue_result(KIND_HDR_SHORT, 1'b0, '0, '0, '0, 1'b1);
      else if (phase == PH_ADDR || phase == PH_PORT_LO || phase == PH_PORT_HI)
        queue_result(KIND_TRUNCATED, 1'b0, '0, '0, '0, 1'b1);
      restart_message();
    end
  endfunction

  // one byte request, with the sender's burst/gap pattern in front of it
  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input kind_e status);
    while (gap_left != 0) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
    if (listen_cfg) bytes_listening++;
    parse_byte(b, last);
    // typed-in status from the directed table replaces the mirrored one
    if (last && typed && pending_results.size() != 0)
      pending_results[pending_results.size()-1].kind = status;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
      gap_left   = $urandom_range(1, 5);
    end
  endtask

  task automatic send_span(ref logic [7:0] m[$], input int from, input int upto,
                           input logic typed, input kind_e status);
    for (int i = from; i < upto; i++)
      push_byte(m[i], i == m.size() - 1, typed, status);
  endtask

  // listening is only written with the block drained
  task automatic write_listening(input logic value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.listening <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    listen_cfg = value;
    cfg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic add_noise(ref logic [7:0] m[$], input int n);
    for (int i = 0; i < n; i++) m.push_back(8'($urandom));
  endtask

  task automatic add_record(ref logic [7:0] m[$], input logic v6, input logic [127:0] addr,
                            input logic [15:0] port);
    m.push_back(v6 ? PREFIX_V6 : PREFIX_V4);
    for (int i = (v6 ? 15 : 3); i >= 0; i--) m.push_back(addr[i*8 +: 8]);
    m.push_back(port[7:0]);
    m.push_back(port[15:8]);
  endtask

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 3))
      0:       return {8'h00, 8'($urandom_range(1, 255))};
      1:       return {8'($urandom_range(1, 255)), 8'h00};
      2:       return 16'hffff;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand_bad_prefix();
    logic [7:0] b;
    do b = 8'($urandom); while (b == PREFIX_V4 || b == PREFIX_V6);
    return b;
  endfunction

  task automatic build_directed(input scenario_t sc, ref logic [7:0] m[$]);
    m.delete();
    if (sc.shape == SH_HEADER) begin
      add_noise(m, sc.extra);
      return;
    end
    add_noise(m, HEADER_BYTES);
    case (sc.shape)
      SH_TWO: begin
        add_record(m, sc.v6, sc.addr, sc.port);
        add_record(m, !sc.v6, ~sc.addr, ~sc.port);
      end
      SH_ZERO_PORT: begin
        add_record(m, sc.v6, sc.addr, 16'h0);
        add_noise(m, sc.extra);
      end
      SH_BAD_PREFIX: begin
        m.push_back(sc.addr[7:0]);
        add_noise(m, sc.extra);
      end
      default: begin
        add_record(m, sc.v6, sc.addr, sc.port);
        if (sc.shape == SH_RECORD && sc.extra != 0)
          while (m.size() > HEADER_BYTES + sc.extra) void'(m.pop_back());
      end
    endcase
  endtask

  task automatic build_random(ref logic [7:0] m[$]);
    int unsigned sel;
    int unsigned nrec;
    int          cut;
    logic        v6;
    sel  = $urandom_range(0, 99);
    nrec = $urandom_range(0, 3);
    m.delete();
    if (sel >= 85 && sel < 92) begin
      add_noise(m, $urandom_range(1, HEADER_BYTES));
      return;
    end
    add_noise(m, HEADER_BYTES);
    if (sel >= 92) begin
      add_noise(m, $urandom_range(1, 20));
      return;
    end
    repeat (nrec) add_record(m, 1'($urandom), rand_addr(), rand_port());
    if (sel >= 50 && sel < 65) begin
      v6 = 1'($urandom);
      add_record(m, v6, rand_addr(), rand_port());
      // end the message inside the last record, after its prefix (7 or 19 bytes long)
      cut = $urandom_range(m.size() - (v6 ? 19 : 7) + 1, m.size() - 1);
      while (m.size() > cut) void'(m.pop_back());
    end else if (sel >= 65 && sel < 75) begin
      add_record(m, 1'($urandom), rand_addr(), 16'h0);
      add_noise(m, $urandom_range(0, 6));
    end else if (sel >= 75) begin
      m.push_back(rand_bad_prefix());
      add_noise(m, $urandom_range(0, 6));
    end
  endtask

  initial begin : stimulus
    logic [7:0] msg[$];
    int         split;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.last_byte  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.listening = 1'b0;
    listen_cfg       = 1'b0;
    rec_v6           = 1'b0;
    shift_hi         = '0;
    shift_lo         = '0;
    port_lo          = '0;
    restart_message();
    burst_left = 8;
    gap_left   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].listen != listen_cfg) write_listening(DIRECTED[i].listen);
      build_directed(DIRECTED[i], msg);
      if (DIRECTED[i].shape == SH_SPLIT) begin
        // bytes dropped before the switch keep the rest of the message muted
        send_span(msg, 0, DIRECTED[i].extra, 1'b0, KIND_DONE);
        write_listening(1'b1);
        send_span(msg, DIRECTED[i].extra, msg.size(), 1'b0, KIND_DONE);
      end else begin
        send_span(msg, 0, msg.size(), DIRECTED[i].typed, DIRECTED[i].status);
      end
    end

    write_listening(1'b1);
    while (bytes_listening < RANDOM_ITEMS) begin
      build_random(msg);
      if (msg.size() > 1 && $urandom_range(0, 9) == 0) begin
        split = $urandom_range(1, msg.size() - 1);
        send_span(msg, 0, split, 1'b0, KIND_DONE);
        write_listening(1'($urandom));
        send_span(msg, split, msg.size(), 1'b0, KIND_DONE);
      end else begin
        send_span(msg, 0, msg.size(), 1'b0, KIND_DONE);
      end
      if (!listen_cfg && $urandom_range(0, 1) == 0)
        write_listening(1'b1);
      else if ($urandom_range(0, 7) == 0)
        write_listening($urandom_range(0, 3) != 0);
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d message bytes (%0d while listening), %0d listening writes,",
             bytes_sent, bytes_listening, cfg_writes);
    $display("%0d address records and %0d status results checked, %0d mismatches",
             records_seen, status_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("** server_address_list_deframer_unit: PASSED **");
    end else begin
      $display("** server_address_list_deframer_unit: FAILED **");
    end
    $finish;
  end

  // result side: ready follows a randomly re-drawn stall pattern
  initial begin : result_sink
    logic [15:0] stall_pat;
    int unsigned cyc;
    out_if.ready = 1'b0;
    stall_pat    = 16'hffff;
    cyc          = 0;
    forever begin
      @(posedge clk_i);
      if (cyc % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hffff;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        if (stall_pat == 16'h0) stall_pat = 16'h0001;
      end
      out_if.ready <= stall_pat[cyc % 16];
      cyc++;
    end
  end

  always @(posedge clk_i) begin : check_results
    addr_result_t want;
    logic         bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (out_if.result_kind == KIND_ADDRESS) records_seen++;
      else status_seen++;
      if (pending_results.size() == 0) begin
        want = '0;
        bad  = 1'b1;
      end else begin
        want = pending_results.pop_front();
        bad  = (out_if.result_kind !== want.kind) || (out_if.is_ipv6 !== want.is_ipv6) ||
               (out_if.address_high !== want.hi) || (out_if.address_low !== want.lo) ||
               (out_if.port_number !== want.port) || (out_if.final_result !== want.fin);
      end
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          if (pending_results.size() == 0 && want == '0)
            $display("t=%0t result with nothing pending:", $realtime);
          $display("t=%0t want kind=%0d v6=%0b hi=%h lo=%h port=%h fin=%0b", $realtime,
                   want.kind, want.is_ipv6, want.hi, want.lo, want.port, want.fin);
          $display("t=%0t got  kind=%0d v6=%0b hi=%h lo=%h port=%h fin=%0b", $realtime,
                   out_if.result_kind, out_if.is_ipv6, out_if.address_high,
                   out_if.address_low, out_if.port_number, out_if.final_result);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no request moved for %0d cycles, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("** server_address_list_deframer_unit: FAILED **");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/sadf_pkg.sv
hdl/sadf_ifs.sv
hdl/sadf_front.sv
hdl/sadf_queue.sv
hdl/sadf_back.sv
hdl/server_address_list_deframer_unit.sv
dv/tb.sv
